>>> rtl/aets_pkg.sv
// Package for the adjacency edge table scan block.
// Holds the field widths, the mode, direction and status codes, the edge
// entry layout and the control state type. No dependencies.
package aets_pkg;

  // Field widths, fixed by the stream payload layout
  localparam int VERTEX_ID_BITS = 32;
  localparam int LABEL_BITS     = 16;

  // Default table depth
  localparam int EDGE_CAPACITY_DEF = 64;

  // Input item kinds (tuser)
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_PAIR   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Query direction filter; any other code passes both directions
  localparam logic [1:0] DIR_IN  = 2'd0;
  localparam logic [1:0] DIR_OUT = 2'd1;

  // Result status (tuser)
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_MATCH    = 2'd2;
  localparam logic [1:0] STAT_NOMATCH  = 2'd3;

  // One stored edge
  typedef struct packed {
    logic                      is_out;
    logic [LABEL_BITS-1:0]     label;
    logic [VERTEX_ID_BITS-1:0] vertex;
  } edge_entry_t;

  localparam int ENTRY_W = $bits(edge_entry_t);

  // Control sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

>>> rtl/aets_edge_mem.sv
// Edge table storage: one write port, one read port, registered read data.
// Depends on aets_pkg for the entry type.
module aets_edge_mem #(
  parameter int DEPTH = aets_pkg::EDGE_CAPACITY_DEF,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  aets_pkg::edge_entry_t wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output aets_pkg::edge_entry_t rd_data
);

  aets_pkg::edge_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/adjacency_edge_table_scan_top.sv
// Adjacency edge table scan: one vertex's edge list in a single-port-read RAM.
// Insert: result in the output register the cycle after it is accepted.
// Query: one RAM read per cycle; no new item is taken until its last result is loaded;
//   the scan stalls only while the output register is held by the sink.
// Reset (rst, synchronous, active high) empties the table and clears control;
//   RAM contents are not cleared and entries are read only after written.
module adjacency_edge_table_scan_top #(
  parameter int EDGE_CAPACITY = aets_pkg::EDGE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: direction[1:0], edge_is_out[2], neighbor_id[34:3],
  //        label[50:35], own_vertex[82:51], zero[87:83]
  input  logic [87:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: first_id[31:0], second_id[63:32]
  output logic [63:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int IDX_W = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(EDGE_CAPACITY + 1);
  localparam int VID_W = aets_pkg::VERTEX_ID_BITS;
  localparam int LBL_W = aets_pkg::LABEL_BITS;

  // Input field unpacking
  logic [1:0]       in_mode;
  logic [1:0]       in_dir;
  logic             in_is_out;
  logic [VID_W-1:0] in_nbr;
  logic [LBL_W-1:0] in_label;
  logic [VID_W-1:0] in_own;

  assign in_mode   = s_axis_tuser;
  assign in_dir    = s_axis_tdata[1:0];
  assign in_is_out = s_axis_tdata[2];
  assign in_nbr    = s_axis_tdata[34:3];
  assign in_label  = s_axis_tdata[50:35];
  assign in_own    = s_axis_tdata[82:51];

  // Control state
  aets_pkg::state_t state, state_next;
  logic [CNT_W-1:0] edge_total;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic             pend_valid;
  logic             out_valid;

  // Query and result payload
  logic [1:0]       q_mode;
  logic [1:0]       q_dir;
  logic [LBL_W-1:0] q_label;
  logic [VID_W-1:0] q_own;
  logic [VID_W-1:0] pend_first;
  logic [VID_W-1:0] pend_second;
  logic [1:0]       out_status;
  logic [VID_W-1:0] out_first;
  logic [VID_W-1:0] out_second;
  logic             out_last;

  // Handshake and sequencing strobes
  logic in_take;
  logic is_query;
  logic is_insert;
  logic table_full;
  logic out_free;
  logic consume;
  logic issue;
  logic scan_done;
  logic load_ins;
  logic load_scan;
  logic load_flush;
  logic wr_en;

  // Entry evaluation
  aets_pkg::edge_entry_t wr_entry;
  aets_pkg::edge_entry_t rd_entry;
  logic             dir_ok;
  logic             label_ok;
  logic             hit;
  logic [VID_W-1:0] hit_first;
  logic [VID_W-1:0] hit_second;

  assign out_free   = !out_valid || m_axis_tready;
  assign table_full = (edge_total == CNT_W'(EDGE_CAPACITY));
  assign is_query   = (in_mode == aets_pkg::MODE_VERTEX) || (in_mode == aets_pkg::MODE_PAIR);
  assign is_insert  = (in_mode == aets_pkg::MODE_INSERT);

  // Edge table RAM
  assign wr_entry = '{is_out: in_is_out, label: in_label, vertex: in_nbr};

  aets_edge_mem #(
    .DEPTH (EDGE_CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (edge_total[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  // Filter and pair forming on the entry just read
  always_comb begin
    case (q_dir)
      aets_pkg::DIR_IN:  dir_ok = !rd_entry.is_out;
      aets_pkg::DIR_OUT: dir_ok = rd_entry.is_out;
      default:           dir_ok = 1'b1;
    endcase
    label_ok = (q_label == '0) || (q_label == rd_entry.label);
    hit      = dir_ok && label_ok;
    if (q_mode == aets_pkg::MODE_VERTEX) begin
      hit_first  = rd_entry.vertex;
      hit_second = '0;
    end else if (rd_entry.is_out) begin
      hit_first  = rd_entry.vertex;
      hit_second = q_own;
    end else begin
      hit_first  = q_own;
      hit_second = rd_entry.vertex;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      aets_pkg::S_IDLE:  if (in_take && is_query) state_next = aets_pkg::S_SCAN;
      aets_pkg::S_SCAN:  if (scan_done) state_next = aets_pkg::S_FLUSH;
      aets_pkg::S_FLUSH: if (out_free) state_next = aets_pkg::S_IDLE;
      default:           state_next = aets_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    consume       = 1'b0;
    issue         = 1'b0;
    scan_done     = 1'b0;
    load_flush    = 1'b0;
    unique case (state)
      aets_pkg::S_IDLE: begin
        s_axis_tready = out_free;
      end
      aets_pkg::S_SCAN: begin
        // a hit behind a held match needs room to push that match out
        consume   = rd_pend && (!hit || !pend_valid || out_free);
        issue     = (rd_idx != edge_total) && (!rd_pend || consume);
        scan_done = (rd_idx == edge_total) && (!rd_pend || consume);
      end
      aets_pkg::S_FLUSH: begin
        load_flush = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign load_ins  = in_take && is_insert;
  assign load_scan = consume && hit && pend_valid;
  assign wr_en     = load_ins && !table_full;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aets_pkg::S_IDLE;
      edge_total <= '0;
      rd_idx     <= '0;
      rd_pend    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        edge_total <= edge_total + CNT_W'(1);
      end
      if (in_take && is_query) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (in_take && is_query) begin
        rd_pend <= 1'b0;
      end else if (issue) begin
        rd_pend <= 1'b1;
      end else if (consume) begin
        rd_pend <= 1'b0;
      end
      if (in_take && is_query) begin
        pend_valid <= 1'b0;
      end else if (consume && hit) begin
        pend_valid <= 1'b1;
      end else if (load_flush) begin
        pend_valid <= 1'b0;
      end
      if (load_ins || load_scan || load_flush) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query latch and held match
  always_ff @(posedge clk) begin
    if (in_take && is_query) begin
      q_mode  <= in_mode;
      q_dir   <= in_dir;
      q_label <= in_label;
      q_own   <= in_own;
    end
    if (consume && hit) begin
      pend_first  <= hit_first;
      pend_second <= hit_second;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_ins) begin
      out_status <= table_full ? aets_pkg::STAT_FULL : aets_pkg::STAT_INSERTED;
      out_first  <= '0;
      out_second <= '0;
      out_last   <= 1'b1;
    end else if (load_scan) begin
      out_status <= aets_pkg::STAT_MATCH;
      out_first  <= pend_first;
      out_second <= pend_second;
      out_last   <= 1'b0;
    end else if (load_flush) begin
      out_status <= pend_valid ? aets_pkg::STAT_MATCH : aets_pkg::STAT_NOMATCH;
      out_first  <= pend_valid ? pend_first : '0;
      out_second <= pend_valid ? pend_second : '0;
      out_last   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {out_second, out_first};

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= CNT_W'(EDGE_CAPACITY))
    else $error("edge count beyond capacity");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == aets_pkg::S_IDLE |-> !rd_pend && !pend_valid)
    else $error("scan state left over in idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == aets_pkg::S_SCAN |-> rd_idx <= edge_total)
    else $error("read index past stored entries");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> edge_total == $past(edge_total) + CNT_W'(1))
    else $error("insert did not advance edge count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_scan |-> out_free)
    else $error("held match pushed into busy output register");

endmodule

>>> tb/sv/adjacency_edge_table_scan_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for adjacency_edge_table_scan_top.
// Drives a directed table and then random insert/query streams, and checks each result
// against an internal copy of the edge table. Depends on aets_pkg and the top level.
module adjacency_edge_table_scan_top_test;

  localparam int EDGE_CAP    = aets_pkg::EDGE_CAPACITY_DEF;
  localparam int IDLE_LIMIT  = 4000;   // cycles without any transaction
  localparam int DRAIN_TICKS = EDGE_CAP + 16;
  localparam int RAND_ITEMS  = 27;     // per idling phase

  // Direction codes beyond the two the package names
  localparam logic [1:0] DIR_BOTH  = 2'd2;
  localparam logic [1:0] DIR_SPARE = 2'd3;

  typedef struct {
    logic [1:0]                          mode;
    logic [1:0]                          dir;
    logic                                is_out;
    logic [aets_pkg::VERTEX_ID_BITS-1:0] nbr;
    logic [aets_pkg::LABEL_BITS-1:0]     label;
    logic [aets_pkg::VERTEX_ID_BITS-1:0] own;
  } edge_req_t;

  typedef struct {
    logic [1:0]                          status;
    logic [aets_pkg::VERTEX_ID_BITS-1:0] first_id;
    logic [aets_pkg::VERTEX_ID_BITS-1:0] second_id;
    logic                                last;
  } edge_rsp_t;

  // typed: expect one result with want_status and zero ids
  typedef struct {
    edge_req_t  req;
    bit         typed;
    logic [1:0] want_status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = aets_pkg::MODE_NONE;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  // Shadow edge table and outstanding results
  aets_pkg::edge_entry_t edge_copy [EDGE_CAP];
  int unsigned edge_copy_total = 0;
  edge_rsp_t   pending_results[$];
  stim_row_t   plan[$];

  int err_count      = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  adjacency_edge_table_scan_top #(.EDGE_CAPACITY(EDGE_CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("%0t ERROR %s", $time, what);
  endfunction

  // Apply one item to the shadow table and list the results it causes
  function automatic void scan_edge_table(input edge_req_t r, ref edge_rsp_t rsp[$]);
    edge_rsp_t             o;
    aets_pkg::edge_entry_t e;
    bit                    dir_ok;
    int                    hits;
    hits = 0;
    o = '{status: aets_pkg::STAT_INSERTED, first_id: '0, second_id: '0, last: 1'b1};
    if (r.mode == aets_pkg::MODE_INSERT) begin
      if (edge_copy_total >= EDGE_CAP) begin
        o.status = aets_pkg::STAT_FULL;
      end else begin
        edge_copy[edge_copy_total] = '{is_out: r.is_out, label: r.label, vertex: r.nbr};
        edge_copy_total++;
      end
      rsp.insert(rsp.size(), o);
    end else if (r.mode != aets_pkg::MODE_NONE) begin
      for (int i = 0; i < int'(edge_copy_total); i++) begin
        e = edge_copy[i];
        case (r.dir)
          aets_pkg::DIR_IN:  dir_ok = !e.is_out;
          aets_pkg::DIR_OUT: dir_ok = e.is_out;
          default:           dir_ok = 1'b1;
        endcase
        if (dir_ok && (r.label == '0 || r.label == e.label)) begin
          o.status = aets_pkg::STAT_MATCH;
          o.last   = 1'b0;
          if (r.mode == aets_pkg::MODE_VERTEX) begin
            o.first_id  = e.vertex;
            o.second_id = '0;
          end else if (e.is_out) begin
            o.first_id  = e.vertex;
            o.second_id = r.own;
          end else begin
            o.first_id  = r.own;
            o.second_id = e.vertex;
          end
          rsp.insert(rsp.size(), o);
          hits++;
        end
      end
      if (hits == 0) begin
        o = '{status: aets_pkg::STAT_NOMATCH, first_id: '0, second_id: '0, last: 1'b1};
        rsp.insert(rsp.size(), o);
      end else begin
        rsp[rsp.size()-1].last = 1'b1;
      end
    end
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [1:0] dir,
                                  input logic is_out, input logic [31:0] nbr,
                                  input logic [15:0] label, input logic [31:0] own,
                                  input bit typed, input logic [1:0] want_status);
    stim_row_t row;
    row.req = '{mode: mode, dir: dir, is_out: is_out, nbr: nbr, label: label, own: own};
    row.typed = typed;
    row.want_status = want_status;
    plan.insert(plan.size(), row);
  endfunction

  // Random item: labels mostly from a small pool so filters hit stored edges
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row.typed = 1'b0;
    row.want_status = aets_pkg::STAT_MATCH;
    row.req.dir    = 2'($urandom);
    row.req.is_out = 1'($urandom);
    row.req.nbr    = $urandom;
    row.req.own    = $urandom;
    pick = $urandom_range(99);
    if (pick < 48)      row.req.mode = aets_pkg::MODE_INSERT;
    else if (pick < 72) row.req.mode = aets_pkg::MODE_VERTEX;
    else if (pick < 96) row.req.mode = aets_pkg::MODE_PAIR;
    else                row.req.mode = aets_pkg::MODE_NONE;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: row.req.label = '0;
      3, 4:    row.req.label = 16'h0001;
      5:       row.req.label = 16'h0002;
      6:       row.req.label = 16'h00A5;
      7:       row.req.label = 16'hFFFF;
      default: row.req.label = 16'($urandom);
    endcase
    return row;
  endfunction

  // Offer one item, wait for the transaction, then record what it should cause
  task automatic drive_row(input stim_row_t row);
    edge_rsp_t rsp[$];
    edge_rsp_t typed_rsp;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {5'b0, row.req.own, row.req.label, row.req.nbr,
                      row.req.is_out, row.req.dir};
    s_axis_tuser  <= row.req.mode;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    scan_edge_table(row.req, rsp);
    if (row.typed) begin
      typed_rsp = '{status: row.want_status, first_id: '0, second_id: '0, last: 1'b1};
      pending_results.insert(pending_results.size(), typed_rsp);
    end else begin
      foreach (rsp[i]) pending_results.insert(pending_results.size(), rsp[i]);
    end
  endtask

  // Sink side: random stall and result check
  always @(posedge clk) begin : rsp_check
    edge_rsp_t got;
    edge_rsp_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, first_id: m_axis_tdata[31:0],
              second_id: m_axis_tdata[63:32], last: m_axis_tlast};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result st=%0d first=%h second=%h last=%0b",
                             got.status, got.first_id, got.second_id, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.first_id !== want.first_id ||
            got.second_id !== want.second_id || got.last !== want.last)
          flag_error($sformatf({"mismatch exp st=%0d first=%h second=%h last=%0b",
                                " got st=%0d first=%h second=%h last=%0b"},
                               want.status, want.first_id, want.second_id, want.last,
                               got.status, got.first_id, got.second_id, got.last));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        sent;

    // Directed table; status typed in where it is plain
    add_row(aets_pkg::MODE_VERTEX, DIR_BOTH, 1'b0, 32'h0000_0000, 16'h0000,
            32'h0000_0000, 1'b1, aets_pkg::STAT_NOMATCH);
    add_row(aets_pkg::MODE_PAIR, aets_pkg::DIR_IN, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
            32'hFFFF_FFFF, 1'b1, aets_pkg::STAT_NOMATCH);
    add_row(aets_pkg::MODE_INSERT, aets_pkg::DIR_IN, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
            32'h0000_0000, 1'b1, aets_pkg::STAT_INSERTED);
    add_row(aets_pkg::MODE_INSERT, aets_pkg::DIR_OUT, 1'b0, 32'h0000_0000, 16'h0001,
            32'hFFFF_FFFF, 1'b1, aets_pkg::STAT_INSERTED);
    add_row(aets_pkg::MODE_INSERT, DIR_BOTH, 1'b1, 32'h1234_5678, 16'h0001,
            32'h0000_0000, 1'b1, aets_pkg::STAT_INSERTED);
    add_row(aets_pkg::MODE_INSERT, DIR_SPARE, 1'b0, 32'h8000_0000, 16'h8000,
            32'hFFFF_FFFF, 1'b1, aets_pkg::STAT_INSERTED);
    // unused mode code: no result, no state change
    add_row(aets_pkg::MODE_NONE, DIR_SPARE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
            32'hFFFF_FFFF, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_VERTEX, aets_pkg::DIR_IN, 1'b0, 32'hFFFF_FFFF, 16'h0000,
            32'h0000_0000, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_VERTEX, aets_pkg::DIR_OUT, 1'b1, 32'h0000_0000, 16'h0000,
            32'hFFFF_FFFF, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_VERTEX, DIR_BOTH, 1'b0, 32'h5555_5555, 16'h0001,
            32'hAAAA_AAAA, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_VERTEX, DIR_SPARE, 1'b1, 32'hAAAA_AAAA, 16'h0000,
            32'h5555_5555, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_PAIR, aets_pkg::DIR_OUT, 1'b0, 32'h0000_0000, 16'hFFFF,
            32'hFFFF_FFFF, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_PAIR, aets_pkg::DIR_IN, 1'b1, 32'hFFFF_FFFF, 16'h0000,
            32'h0000_0000, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_PAIR, DIR_BOTH, 1'b0, 32'h0F0F_0F0F, 16'h0000,
            32'hA5A5_A5A5, 1'b0, aets_pkg::STAT_MATCH);
    add_row(aets_pkg::MODE_PAIR, DIR_SPARE, 1'b1, 32'hF0F0_F0F0, 16'h1234,
            32'h5A5A_5A5A, 1'b1, aets_pkg::STAT_NOMATCH);
    // label present but only on an incoming edge
    add_row(aets_pkg::MODE_VERTEX, aets_pkg::DIR_OUT, 1'b0, 32'h0000_0000, 16'h8000,
            32'h0000_0000, 1'b1, aets_pkg::STAT_NOMATCH);
    add_row(aets_pkg::MODE_INSERT, DIR_SPARE, 1'b1, 32'hDEAD_0001, 16'h00A5,
            32'hFFFF_FFFF, 1'b1, aets_pkg::STAT_INSERTED);
    add_row(aets_pkg::MODE_PAIR, DIR_BOTH, 1'b1, 32'hFFFF_FFFF, 16'h0000,
            32'h5A5A_5A5A, 1'b0, aets_pkg::STAT_MATCH);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) drive_row(plan[i]);

    // Random part over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 77; end
        default: begin send_idle_pct = 35; recv_stall_pct <= 35; end
      endcase
      sent = 0;
      while (sent < RAND_ITEMS) begin
        row = random_row();
        drive_row(row);
        if (row.req.mode != aets_pkg::MODE_NONE) sent++;
      end
    end

    // Fill to capacity, hit the full case, then scan the whole table
    while (edge_copy_total < EDGE_CAP + 2) begin
      row = random_row();
      row.req.mode = aets_pkg::MODE_INSERT;
      drive_row(row);
      if (edge_copy_total == EDGE_CAP) begin
        drive_row(row);
        drive_row(row);
        break;
      end
    end
    row = random_row();
    row.req.mode  = aets_pkg::MODE_VERTEX;
    row.req.dir   = DIR_BOTH;
    row.req.label = '0;
    drive_row(row);
    row.req.mode = aets_pkg::MODE_PAIR;
    row.req.dir  = DIR_SPARE;
    drive_row(row);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
